// ----- hdl/ggnh_pkg.sv -----
// Shared types and constants of the greedy geographic next-hop table.
`default_nettype none

package ggnh_pkg;

	// Width of every external payload field that carries an id or a coordinate.
	localparam int FIELD_W = 16;

	// Defaults of the top-level parameters.
	localparam int MAX_NEIGHBORS_DEF = 64;
	localparam int ID_BITS_DEF       = 16;
	localparam int COORD_BITS_DEF    = 16;

	// Item opcodes.
	localparam logic OPC_HELLO = 1'b0;
	localparam logic OPC_QUERY = 1'b1;

	// Configuration register indexes.
	localparam int  CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SELF_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SELF_Y = 1'b1;

	// Sideband that travels with each candidate through the distance pipeline.
	typedef struct packed {
		logic vld;      // a candidate occupies this stage
		logic self_pt;  // the candidate is the own node, not a stored neighbor
		logic last;     // final candidate of the current item
	} dtag_t;

endpackage

`default_nettype wire

// ----- hdl/ggnh_mem.sv -----
// Neighbor table storage: one synchronous memory with a registered read port.
`default_nettype none

module ggnh_mem #(
	parameter int DEPTH = ggnh_pkg::MAX_NEIGHBORS_DEF,
	parameter int AW    = 6,
	parameter int WIDTH = 48
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/ggnh_dist.sv -----
// Four-stage pipeline that computes the exact squared distance of two points.
`default_nettype none

module ggnh_dist #(
	parameter int CW  = ggnh_pkg::COORD_BITS_DEF,
	parameter int IDW = ggnh_pkg::ID_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ggnh_pkg::dtag_t       tag_in,
	input  wire logic signed [CW-1:0]  ax,
	input  wire logic signed [CW-1:0]  ay,
	input  wire logic signed [CW-1:0]  bx,
	input  wire logic signed [CW-1:0]  by,
	input  wire logic [IDW-1:0]        id_in,
	output ggnh_pkg::dtag_t            tag_out,
	output logic [2*CW:0]              dsq,
	output logic [IDW-1:0]             id_out
);

	ggnh_pkg::dtag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic [IDW-1:0]     id_s1, id_s2, id_s3, id_s4;
	logic signed [CW:0] dx_s1, dy_s1;
	logic [CW-1:0]      mx_s2, my_s2;
	logic [2*CW-1:0]    sx_s3, sy_s3;
	logic [2*CW:0]      sum_s4;
	logic [CW:0]        mx_full, my_full;

	// Sideband travels with the data; only its valid bit needs a reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// Magnitudes of the differences; they always fit in CW bits.
	assign mx_full = dx_s1[CW] ? (CW+1)'(-dx_s1) : (CW+1)'(dx_s1);
	assign my_full = dy_s1[CW] ? (CW+1)'(-dy_s1) : (CW+1)'(dy_s1);

	// Data path: difference, magnitude, square, sum.
	always_ff @(posedge clk) begin
		dx_s1  <= $signed({ax[CW-1], ax}) - $signed({bx[CW-1], bx});
		dy_s1  <= $signed({ay[CW-1], ay}) - $signed({by[CW-1], by});
		id_s1  <= id_in;
		mx_s2  <= mx_full[CW-1:0];
		my_s2  <= my_full[CW-1:0];
		id_s2  <= id_s1;
		sx_s3  <= mx_s2 * mx_s2;
		sy_s3  <= my_s2 * my_s2;
		id_s3  <= id_s2;
		sum_s4 <= {1'b0, sx_s3} + {1'b0, sy_s3};
		id_s4  <= id_s3;
	end

	assign tag_out = tag_s4;
	assign dsq     = sum_s4;
	assign id_out  = id_s4;

endmodule

`default_nettype wire

// ----- hdl/greedy_geo_next_hop_table.sv -----
// Top level of the greedy geographic next-hop table with its item sequencer.
//
// Usage: items enter on in_valid/in_ready. A hello item (opcode 0) updates the
// position of a known neighbor id or appends a new neighbor; added_new and
// table_full_drop report what happened. A query item (opcode 1) returns in
// next_hop_id the stored neighbor nearest the destination that is strictly
// nearer than the own node, with hop_found set; equal distances keep the
// earlier entry. Every item gives exactly one result on out_valid/out_ready.
// The own position is written on the cfg_wr_en/cfg_index/cfg_data port; the user
// must write it only while the block is idle, which the block does not enforce.
// Timing: one item is worked on at a time. The neighbor memory is scanned one
// entry per cycle through its single read port for a hello or a query; a hello
// with an empty table skips the scan. A query's result also waits for the
// own-node candidate, the read register and the four-stage distance pipeline.
// in_ready is high only while no item is in work, so a new item is taken only
// after the result of the last one has been loaded into the output register.
// Reset clears the entry count and own position; table contents need no clear.
// If the receiver stalls, the finished result waits in the output register
// and the block holds the next result until that register is free.
`default_nettype none

module greedy_geo_next_hop_table #(
	parameter int MAX_NEIGHBORS = ggnh_pkg::MAX_NEIGHBORS_DEF,
	parameter int ID_BITS       = ggnh_pkg::ID_BITS_DEF,
	parameter int COORD_BITS    = ggnh_pkg::COORD_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [ggnh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ggnh_pkg::FIELD_W-1:0]      cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              opcode,
	input  wire logic [ggnh_pkg::FIELD_W-1:0]      node_id,
	input  wire logic signed [ggnh_pkg::FIELD_W-1:0] pos_x,
	input  wire logic signed [ggnh_pkg::FIELD_W-1:0] pos_y,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   hop_found,
	output logic [ggnh_pkg::FIELD_W-1:0]           next_hop_id,
	output logic                                   added_new,
	output logic                                   table_full_drop
);

	localparam int AW    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
	localparam int CW    = COORD_BITS;
	localparam int SUM_W = 2 * CW + 1;
	localparam int MW    = ID_BITS + 2 * CW;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NEIGHBORS);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SELF   = 5'b00010,
		S_SCAN   = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t               state_q;
	logic                 op_q;
	logic [ID_BITS-1:0]   op_id_q;
	logic signed [CW-1:0] op_x_q, op_y_q;
	logic [ggnh_pkg::FIELD_W-1:0] self_x_q, self_y_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [AW-1:0]        scan_q;
	logic [AW-1:0]        idx_s1;
	ggnh_pkg::dtag_t      tag_s1;
	ggnh_pkg::dtag_t      issue_tag;
	logic                 match_q;
	logic [AW-1:0]        match_idx_q;
	logic [SUM_W-1:0]     best_q;
	logic                 found_q;
	logic [ID_BITS-1:0]   hop_q;
	logic                 out_valid_q, hop_found_q, added_new_q, drop_q;
	logic [ggnh_pkg::FIELD_W-1:0] next_hop_q;

	logic                 accept;
	logic                 scan_last;
	logic                 out_free;
	logic [31:0]          in_id_z, in_x_z, in_y_z, self_x_z, self_y_z, hop_z;
	logic signed [CW-1:0] self_x_c, self_y_c;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [MW-1:0]        mem_wdata, mem_rdata;
	logic [ID_BITS-1:0]   rd_id;
	logic signed [CW-1:0] rd_x, rd_y;
	ggnh_pkg::dtag_t      dist_tag_in, dist_tag_out;
	logic [SUM_W-1:0]     cand_dsq;
	logic [ID_BITS-1:0]   dist_id;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// Field conversion: fields are taken as 16-bit patterns, then cut or widened.
	assign in_id_z  = 32'(node_id);
	assign in_x_z   = 32'($unsigned(pos_x));
	assign in_y_z   = 32'($unsigned(pos_y));
	assign self_x_z = 32'(self_x_q);
	assign self_y_z = 32'(self_y_q);
	assign self_x_c = self_x_z[CW-1:0];
	assign self_y_c = self_y_z[CW-1:0];

	// Memory word layout: id, then x, then y.
	assign rd_id = mem_rdata[MW-1 -: ID_BITS];
	assign rd_x  = mem_rdata[2*CW-1 -: CW];
	assign rd_y  = mem_rdata[CW-1:0];

	assign scan_last = ((CNT_W'(scan_q) + CNT_W'(1)) == cnt_q);

	// Candidate issue: the own node first for a query, then one entry per cycle.
	always_comb begin
		issue_tag = '0;
		case (state_q)
			S_SELF: begin
				issue_tag.vld     = 1'b1;
				issue_tag.self_pt = 1'b1;
				issue_tag.last    = (cnt_q == '0);
			end
			S_SCAN: begin
				issue_tag.vld  = 1'b1;
				issue_tag.last = scan_last;
			end
			default: begin
				issue_tag = '0;
			end
		endcase
	end

	// Hello write-back happens as the result is loaded.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = match_idx_q;
		mem_wdata = {op_id_q, op_x_q, op_y_q};
		if (state_q == S_FINISH && out_free && op_q == ggnh_pkg::OPC_HELLO) begin
			if (match_q) begin
				mem_we = 1'b1;
			end else if (cnt_q != MAX_CNT) begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[AW-1:0];
			end
		end
	end

	ggnh_mem #(
		.DEPTH(MAX_NEIGHBORS),
		.AW   (AW),
		.WIDTH(MW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (state_q == S_SCAN),
		.raddr(scan_q),
		.rdata(mem_rdata)
	);

	// Only query candidates enter the distance pipeline.
	always_comb begin
		dist_tag_in     = tag_s1;
		dist_tag_in.vld = tag_s1.vld && (op_q == ggnh_pkg::OPC_QUERY);
	end

	ggnh_dist #(
		.CW (CW),
		.IDW(ID_BITS)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.tag_in (dist_tag_in),
		.ax     (tag_s1.self_pt ? self_x_c : rd_x),
		.ay     (tag_s1.self_pt ? self_y_c : rd_y),
		.bx     (op_x_q),
		.by     (op_y_q),
		.id_in  (rd_id),
		.tag_out(dist_tag_out),
		.dsq    (cand_dsq),
		.id_out (dist_id)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_x_q <= '0;
			self_y_q <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index == ggnh_pkg::REG_SELF_X) begin
				self_x_q <= cfg_data;
			end
			if (cfg_index == ggnh_pkg::REG_SELF_Y) begin
				self_y_q <= cfg_data;
			end
		end
	end

	// Item payload is captured on acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode;
			op_id_q <= in_id_z[ID_BITS-1:0];
			op_x_q  <= in_x_z[CW-1:0];
			op_y_q  <= in_y_z[CW-1:0];
		end
		idx_s1 <= scan_q;
	end

	// Sequencer, scan counter and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q  <= '0;
			cnt_q   <= '0;
			tag_s1  <= '0;
		end else begin
			tag_s1 <= issue_tag;
			case (state_q)
				S_IDLE: begin
					scan_q <= '0;
					if (accept) begin
						if (opcode == ggnh_pkg::OPC_QUERY) begin
							state_q <= S_SELF;
						end else if (cnt_q == '0) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SELF: begin
					state_q <= (cnt_q == '0) ? S_DRAIN : S_SCAN;
				end
				S_SCAN: begin
					scan_q <= scan_q + AW'(1);
					if (scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (op_q == ggnh_pkg::OPC_HELLO) begin
						if (tag_s1.vld && tag_s1.last) begin
							state_q <= S_FINISH;
						end
					end else if (dist_tag_out.vld && dist_tag_out.last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (op_q == ggnh_pkg::OPC_HELLO && !match_q && cnt_q != MAX_CNT) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hello lookup: remember the first entry whose id matches.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (accept) begin
			match_q <= 1'b0;
		end else if (tag_s1.vld && op_q == ggnh_pkg::OPC_HELLO && !match_q
				&& rd_id == op_id_q) begin
			match_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s1.vld && !match_q && rd_id == op_id_q) begin
			match_idx_q <= idx_s1;
		end
	end

	// Query selection: the own distance seeds the bound, a strictly smaller one wins.
	always_ff @(posedge clk) begin
		if (dist_tag_out.vld) begin
			if (dist_tag_out.self_pt) begin
				best_q  <= cand_dsq;
				found_q <= 1'b0;
				hop_q   <= '0;
			end else if (cand_dsq < best_q) begin
				best_q  <= cand_dsq;
				found_q <= 1'b1;
				hop_q   <= dist_id;
			end
		end
	end

	always_comb begin
		hop_z = '0;
		hop_z[ID_BITS-1:0] = hop_q;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			if (op_q == ggnh_pkg::OPC_QUERY) begin
				hop_found_q <= found_q;
				next_hop_q  <= found_q ? hop_z[ggnh_pkg::FIELD_W-1:0] : '0;
				added_new_q <= 1'b0;
				drop_q      <= 1'b0;
			end else begin
				hop_found_q <= 1'b0;
				next_hop_q  <= '0;
				added_new_q <= !match_q && (cnt_q != MAX_CNT);
				drop_q      <= !match_q && (cnt_q == MAX_CNT);
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign hop_found       = hop_found_q;
	assign next_hop_id     = next_hop_q;
	assign added_new       = added_new_q;
	assign table_full_drop = drop_q;

endmodule

`default_nettype wire

// ----- dv/greedy_geo_next_hop_table_tb.sv -----
// Self-checking testbench for the greedy geographic next-hop table.
`default_nettype none

module greedy_geo_next_hop_table_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASE_ITEMS  = 75;
	localparam int NUM_PHASES   = 6;
	localparam int NUM_ROWS     = 20;
	localparam int POOL_SIZE    = 96;
	localparam int FW           = ggnh_pkg::FIELD_W;
	localparam int NB_MAX       = ggnh_pkg::MAX_NEIGHBORS_DEF;

	typedef struct packed {
		logic                 hop_found;
		logic [FW-1:0]        next_hop_id;
		logic                 added_new;
		logic                 table_full_drop;
	} hop_result_t;

	typedef struct packed {
		logic                      op;
		logic [FW-1:0]             id;
		logic signed [FW-1:0]      x;
		logic signed [FW-1:0]      y;
		logic                      typed;
		hop_result_t               exp;
	} dir_row_t;

	localparam hop_result_t NO_HOP = '0;
	localparam hop_result_t ADDED  = '{1'b0, 16'h0000, 1'b1, 1'b0};

	// Block ports.
	logic                        clk;
	logic                        arst_n;
	logic                        cfg_wr_en;
	logic [ggnh_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [FW-1:0]               cfg_data;
	logic                        in_valid;
	logic                        in_ready;
	logic                        opcode;
	logic [FW-1:0]               node_id;
	logic signed [FW-1:0]        pos_x;
	logic signed [FW-1:0]        pos_y;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic                        hop_found;
	logic [FW-1:0]               next_hop_id;
	logic                        added_new;
	logic                        table_full_drop;

	// Typed expectation that travels with a directed item.
	logic                        row_typed;
	hop_result_t                 row_exp;

	// Predictor state: own position and neighbor table.
	logic signed [FW-1:0]        own_x;
	logic signed [FW-1:0]        own_y;
	logic [FW-1:0]               nb_id [NB_MAX];
	logic signed [FW-1:0]        nb_x [NB_MAX];
	logic signed [FW-1:0]        nb_y [NB_MAX];
	int                          nb_count;

	hop_result_t                 pending_hops [$];
	dir_row_t                    directed_rows [NUM_ROWS];
	logic [FW-1:0]               id_pool [POOL_SIZE];
	int                          err_cnt;
	int                          cycle_cnt;
	int                          stall_mode;
	int                          burst_left;

	greedy_geo_next_hop_table dut (.*);

	// Clock with a period of 10.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Squared Euclidean distance, exact in 64 bits.
	function automatic longint sq_dist(logic signed [FW-1:0] ax, logic signed [FW-1:0] ay,
			logic signed [FW-1:0] bx, logic signed [FW-1:0] by);
		longint dx;
		longint dy;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		return dx * dx + dy * dy;
	endfunction

	// Applies one item to the neighbor table and returns the result it gives.
	function automatic hop_result_t next_hop_or_learn(logic op, logic [FW-1:0] id,
			logic signed [FW-1:0] x, logic signed [FW-1:0] y);
		hop_result_t r;
		longint best;
		longint d;
		r = '0;
		if (op == ggnh_pkg::OPC_HELLO) begin
			for (int i = 0; i < nb_count; i++) begin
				if (nb_id[i] == id) begin
					nb_x[i] = x;
					nb_y[i] = y;
					return r;
				end
			end
			if (nb_count < NB_MAX) begin
				nb_id[nb_count] = id;
				nb_x[nb_count] = x;
				nb_y[nb_count] = y;
				nb_count++;
				r.added_new = 1'b1;
			end else begin
				r.table_full_drop = 1'b1;
			end
			return r;
		end
		// Only a neighbor strictly nearer than the own node qualifies; ties keep the first.
		best = sq_dist(own_x, own_y, x, y);
		for (int i = 0; i < nb_count; i++) begin
			d = sq_dist(nb_x[i], nb_y[i], x, y);
			if (d < best) begin
				best = d;
				r.hop_found = 1'b1;
				r.next_hop_id = nb_id[i];
			end
		end
		return r;
	endfunction

	// A coordinate weighted toward the extremes and the area around zero.
	function automatic logic signed [FW-1:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return $urandom_range(0, 1) ? 16'sh0000 : 16'shffff;
			3, 4: return 16'(int'($urandom_range(0, 512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
		if (err_cnt < 50)
			$display("MISMATCH %s: got %h expected %h (cycle %0d)", what, got_v, want_v, cycle_cnt);
		err_cnt++;
	endtask

	task automatic check_result(hop_result_t got, hop_result_t want);
		if (got.hop_found !== want.hop_found)
			report_mismatch("hop_found", got.hop_found, want.hop_found);
		if (got.next_hop_id !== want.next_hop_id)
			report_mismatch("next_hop_id", got.next_hop_id, want.next_hop_id);
		if (got.added_new !== want.added_new)
			report_mismatch("added_new", got.added_new, want.added_new);
		if (got.table_full_drop !== want.table_full_drop)
			report_mismatch("table_full_drop", got.table_full_drop, want.table_full_drop);
	endtask

	// Offers one item and holds it until the block takes it.
	task automatic send_item(logic op, logic [FW-1:0] id, logic signed [FW-1:0] x,
			logic signed [FW-1:0] y, logic typed, hop_result_t exp);
		in_valid <= 1'b1;
		opcode <= op;
		node_id <= id;
		pos_x <= x;
		pos_y <= y;
		row_typed <= typed;
		row_exp <= exp;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
	endtask

	// Sender pacing: bursts of items with gaps of random length between them.
	task automatic pace_sender(bit no_gaps);
		int gap;
		if (no_gaps)
			return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 7);
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending until every item has returned its result.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_hops.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_own_pos(logic signed [FW-1:0] x, logic signed [FW-1:0] y);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_index <= ggnh_pkg::REG_SELF_X;
		cfg_data <= x;
		@(posedge clk);
		cfg_index <= ggnh_pkg::REG_SELF_Y;
		cfg_data <= y;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Receiver stall pattern, chosen per phase.
	always @(posedge clk) begin
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 2) != 0);
			default: out_ready <= ((cycle_cnt % 7) < 3);
		endcase
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Tracks register writes, predicts each accepted item and checks each result.
	always @(posedge clk) begin
		hop_result_t got;
		hop_result_t want;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
					ggnh_pkg::REG_SELF_X: own_x = cfg_data;
					ggnh_pkg::REG_SELF_Y: own_y = cfg_data;
					default: ;
				endcase
			end
			if (out_valid === 1'b1 && out_ready) begin
				got = '{hop_found, next_hop_id, added_new, table_full_drop};
				if (pending_hops.size() == 0) begin
					report_mismatch("result with no item waiting", got, '0);
				end else begin
					want = pending_hops.pop_front();
					check_result(got, want);
				end
			end
			if (in_valid && in_ready === 1'b1) begin
				want = next_hop_or_learn(opcode, node_id, pos_x, pos_y);
				if (row_typed)
					want = row_exp;
				pending_hops = {pending_hops, want};
			end
		end
	end

	initial begin
		int k;
		logic op;
		logic [FW-1:0] id;
		logic signed [FW-1:0] x;
		logic signed [FW-1:0] y;
		logic signed [FW-1:0] sx;
		logic signed [FW-1:0] sy;
		int hello_pct;

		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= ggnh_pkg::REG_SELF_X;
		cfg_data <= '0;
		in_valid <= 1'b0;
		opcode <= ggnh_pkg::OPC_HELLO;
		node_id <= '0;
		pos_x <= '0;
		pos_y <= '0;
		row_typed <= 1'b0;
		row_exp <= '0;
		own_x = '0;
		own_y = '0;
		nb_count = 0;
		err_cnt = 0;
		cycle_cnt = 0;
		stall_mode = 1;
		burst_left = 0;
		foreach (id_pool[i])
			id_pool[i] = 16'($urandom);

		// Directed items with the own node at the origin.
		directed_rows = '{
			'{ggnh_pkg::OPC_QUERY, 16'h0000, 16'sh0000, 16'sh0000, 1'b1, NO_HOP},  // empty table
			'{ggnh_pkg::OPC_QUERY, 16'hffff, 16'sh8000, 16'sh8000, 1'b1, NO_HOP},
			'{ggnh_pkg::OPC_QUERY, 16'h5555, 16'sh7fff, 16'sh7fff, 1'b1, NO_HOP},
			'{ggnh_pkg::OPC_HELLO, 16'h0000, 16'sh7fff, 16'sh7fff, 1'b1, ADDED},
			'{ggnh_pkg::OPC_HELLO, 16'hffff, 16'sh8000, 16'sh8000, 1'b1, ADDED},
			'{ggnh_pkg::OPC_QUERY, 16'h0000, 16'sh8000, 16'sh8000, 1'b1,
				'{1'b1, 16'hffff, 1'b0, 1'b0}},
			'{ggnh_pkg::OPC_QUERY, 16'h0000, 16'sh7fff, 16'sh7fff, 1'b1,
				'{1'b1, 16'h0000, 1'b0, 1'b0}},
			// Known id: position moves, nothing is appended.
			'{ggnh_pkg::OPC_HELLO, 16'hffff, 16'sh1234, 16'shedcb, 1'b1, NO_HOP},
			'{ggnh_pkg::OPC_QUERY, 16'haaaa, 16'sh0000, 16'sh0000, 1'b0, NO_HOP},
			'{ggnh_pkg::OPC_HELLO, 16'h0005, 16'sh0000, 16'sh0000, 1'b1, ADDED},
			// Same distance as the own node is not strictly nearer.
			'{ggnh_pkg::OPC_QUERY, 16'h0000, 16'sh0000, 16'sh0000, 1'b1, NO_HOP},
			'{ggnh_pkg::OPC_HELLO, 16'h0006, 16'sh000a, 16'sh0064, 1'b1, ADDED},
			'{ggnh_pkg::OPC_HELLO, 16'h0007, -16'sh000a, 16'sh0064, 1'b1, ADDED},
			// Equal distances keep the earlier entry.
			'{ggnh_pkg::OPC_QUERY, 16'h0000, 16'sh0000, 16'sh0064, 1'b1,
				'{1'b1, 16'h0006, 1'b0, 1'b0}},
			'{ggnh_pkg::OPC_HELLO, 16'h5a5a, 16'shffff, 16'sh0001, 1'b1, ADDED},
			'{ggnh_pkg::OPC_HELLO, 16'ha5a5, 16'sh5555, 16'shaaaa, 1'b1, ADDED},
			'{ggnh_pkg::OPC_QUERY, 16'h1234, 16'sh5555, 16'shaaaa, 1'b0, NO_HOP},
			'{ggnh_pkg::OPC_QUERY, 16'hfedc, 16'shffff, 16'sh0001, 1'b0, NO_HOP},
			'{ggnh_pkg::OPC_HELLO, 16'h0000, 16'sh8000, 16'sh7fff, 1'b1, NO_HOP},
			// Neighbor exactly on the destination, with id zero.
			'{ggnh_pkg::OPC_QUERY, 16'h0000, 16'sh8000, 16'sh7fff, 1'b1,
				'{1'b1, 16'h0000, 1'b0, 1'b0}}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			send_item(directed_rows[r].op, directed_rows[r].id, directed_rows[r].x,
				directed_rows[r].y, directed_rows[r].typed, directed_rows[r].exp);
			pace_sender(1'b0);
		end

		// Random phases, each with its own position of the own node.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin sx = 16'sh7fff; sy = 16'sh7fff; end
				1: begin sx = 16'sh8000; sy = 16'sh8000; end
				2: begin sx = 16'sh8000; sy = 16'sh7fff; end
				5: begin sx = 16'sh0000; sy = 16'sh0000; end
				default: begin sx = pick_coord(); sy = pick_coord(); end
			endcase
			write_own_pos(sx, sy);
			stall_mode = (p == 1) ? 0 : (p % 2) + 1;
			hello_pct = (p == 0) ? 65 : 40;
			burst_left = 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < hello_pct) begin
					op = ggnh_pkg::OPC_HELLO;
					id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
						: 16'($urandom);
					x = pick_coord();
					y = pick_coord();
				end else begin
					op = ggnh_pkg::OPC_QUERY;
					id = 16'($urandom);
					// Often aim near a stored neighbor so that hops are found.
					if (nb_count > 0 && $urandom_range(0, 2) == 0) begin
						k = $urandom_range(0, nb_count - 1);
						x = nb_x[k] + 16'(int'($urandom_range(0, 64)) - 32);
						y = nb_y[k] + 16'(int'($urandom_range(0, 64)) - 32);
					end else begin
						x = pick_coord();
						y = pick_coord();
					end
				end
				send_item(op, id, x, y, 1'b0, NO_HOP);
				pace_sender(p == 1);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_hops.size() != 0)
			report_mismatch("results never returned", pending_hops.size(), 0);
		if (err_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/ggnh_pkg.sv
hdl/ggnh_mem.sv
hdl/ggnh_dist.sv
hdl/greedy_geo_next_hop_table.sv
dv/greedy_geo_next_hop_table_tb.sv
